// ----- sv/tipid_pkg.sv -----
// ----------------------------------------------------------------------------
// tipid_pkg: shared types and constants for the incremental PID tuner core
// Field widths, register map, string codes and the target error lookup.
// ----------------------------------------------------------------------------
package tipid_pkg;

   localparam int unsigned CodeWidth    = 3;
   localparam int unsigned FreqWidth    = 16;
   localparam int unsigned GainWidth    = 16;
   localparam int unsigned TargetWidth  = 10;
   localparam int unsigned FracBits     = 6;
   localparam int unsigned TableWidth   = 60;
   localparam int unsigned ErrWidth     = 18;
   localparam int unsigned DiffWidth    = 19;
   localparam int unsigned Diff2Width   = 20;
   localparam int unsigned ProdPWidth   = GainWidth + DiffWidth;
   localparam int unsigned ProdIWidth   = GainWidth + ErrWidth;
   localparam int unsigned ProdDWidth   = GainWidth + Diff2Width;
   localparam int unsigned SumWidth     = ProdDWidth + 2;
   localparam int unsigned NegWidth     = SumWidth + 1;
   localparam int unsigned ScaleShift   = 8;
   localparam int unsigned AngleWidth   = 32;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned RegIdxWidth  = 2;

   // register indexes (byte address = 8 * index)
   localparam logic [RegIdxWidth-1:0] REG_GAIN_P  = 2'd0;
   localparam logic [RegIdxWidth-1:0] REG_GAIN_I  = 2'd1;
   localparam logic [RegIdxWidth-1:0] REG_GAIN_D  = 2'd2;
   localparam logic [RegIdxWidth-1:0] REG_TARGETS = 2'd3;

   localparam logic [TableWidth-1:0] TABLE_RESET = 60'd92444896685972810;

   localparam logic [CodeWidth-1:0] CODE_NONE    = 3'd0;
   localparam logic [CodeWidth-1:0] CODE_HIGH_E  = 3'd1;
   localparam logic [CodeWidth-1:0] CODE_B       = 3'd2;
   localparam logic [CodeWidth-1:0] CODE_G       = 3'd3;
   localparam logic [CodeWidth-1:0] CODE_D       = 3'd4;
   localparam logic [CodeWidth-1:0] CODE_A       = 3'd5;
   localparam logic [CodeWidth-1:0] CODE_LOW_E   = 3'd6;
   localparam logic [CodeWidth-1:0] CODE_INVALID = 3'd7;

   typedef struct packed {
      logic signed [GainWidth-1:0] gain_p;
      logic signed [GainWidth-1:0] gain_i;
      logic signed [GainWidth-1:0] gain_d;
      logic        [TableWidth-1:0] targets;
      logic                         clear_history;
   } csr_cfg_type;

   // target minus measured, both Q.6; zero for no string or an invalid code
   function automatic logic signed [ErrWidth-1:0] target_error(
      input logic [CodeWidth-1:0]  code,
      input logic [FreqWidth-1:0]  meas,
      input logic [TableWidth-1:0] targets
   );
      logic [TargetWidth-1:0] hz;
      logic                   known;
      logic [ErrWidth-1:0]    diff;
      hz    = '0;
      known = 1'b1;
      unique case (code)
         CODE_NONE:    known = 1'b0;
         CODE_HIGH_E:  hz = targets[9:0];
         CODE_B:       hz = targets[19:10];
         CODE_G:       hz = targets[29:20];
         CODE_D:       hz = targets[39:30];
         CODE_A:       hz = targets[49:40];
         CODE_LOW_E:   hz = targets[59:50];
         CODE_INVALID: known = 1'b0;
         default:      known = 1'b0;
      endcase
      diff = {2'b00, hz, {FracBits{1'b0}}} - {2'b00, meas};
      return known ? signed'(diff) : '0;
   endfunction

endpackage

// ----- sv/tuner_incremental_pid_core.sv -----
// ----------------------------------------------------------------------------
// tuner_incremental_pid_core: incremental PID drive for a string tuner
// Error, difference history, gain products and scaled negated output.
// ----------------------------------------------------------------------------
// The core takes one (string code, measured frequency) transfer per clock while
// req_ready is high and returns one drive angle per transfer. Each item passes
// through the stage one, two and three registers before rsp_valid rises.
// Stage one looks up the target and forms the error and its first
// and second differences (the history updates here, so items may follow each
// other in every cycle), stage two forms the three gain products, stage three
// sums, negates and scales them to 6 fraction bits with floor rounding.
// req_ready drops only when all three stages hold items and the result is
// not taken. Any register write clears the error history.
module tuner_incremental_pid_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tipid_pkg::CodeWidth-1:0]     req_string_code,
   input  logic [tipid_pkg::FreqWidth-1:0]     req_measured_frequency,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tipid_pkg::AngleWidth-1:0] rsp_drive_angle,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tipid_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [tipid_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [tipid_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                csr_pready
);

   tipid_pkg::csr_cfg_type cfg;

   tipid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // pipeline flow control
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;
   logic accept;

   assign adv3      = !v3_ff || rsp_ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // stage one: error and differences, history update
   logic signed [tipid_pkg::ErrWidth-1:0]   prev_err_ff;
   logic signed [tipid_pkg::DiffWidth-1:0]  prev_derr_ff;
   logic signed [tipid_pkg::ErrWidth-1:0]   err_in;
   logic signed [tipid_pkg::DiffWidth-1:0]  derr_in;
   logic signed [tipid_pkg::Diff2Width-1:0] dderr_in;
   logic signed [tipid_pkg::ErrWidth-1:0]   s1_err_ff;
   logic signed [tipid_pkg::DiffWidth-1:0]  s1_derr_ff;
   logic signed [tipid_pkg::Diff2Width-1:0] s1_dderr_ff;

   always_comb begin
      err_in   = tipid_pkg::target_error(req_string_code, req_measured_frequency,
                                         cfg.targets);
      derr_in  = tipid_pkg::DiffWidth'(err_in) - tipid_pkg::DiffWidth'(prev_err_ff);
      dderr_in = tipid_pkg::Diff2Width'(derr_in) - tipid_pkg::Diff2Width'(prev_derr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.clear_history) begin
         prev_err_ff  <= '0;
         prev_derr_ff <= '0;
      end else if (accept) begin
         prev_err_ff  <= err_in;
         prev_derr_ff <= derr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_err_ff   <= err_in;
         s1_derr_ff  <= derr_in;
         s1_dderr_ff <= dderr_in;
      end
   end

   // stage two: gain products
   logic signed [tipid_pkg::ProdPWidth-1:0] prod_p_in, prod_p_ff;
   logic signed [tipid_pkg::ProdIWidth-1:0] prod_i_in, prod_i_ff;
   logic signed [tipid_pkg::ProdDWidth-1:0] prod_d_in, prod_d_ff;

   always_comb begin
      prod_p_in = tipid_pkg::ProdPWidth'(cfg.gain_p) * tipid_pkg::ProdPWidth'(s1_derr_ff);
      prod_i_in = tipid_pkg::ProdIWidth'(cfg.gain_i) * tipid_pkg::ProdIWidth'(s1_err_ff);
      prod_d_in = tipid_pkg::ProdDWidth'(cfg.gain_d) * tipid_pkg::ProdDWidth'(s1_dderr_ff);
   end

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   // stage three: sum, negate, floor-scale from 14 to 6 fraction bits
   logic signed [tipid_pkg::SumWidth-1:0]   sum;
   logic signed [tipid_pkg::NegWidth-1:0]   neg;
   logic signed [tipid_pkg::NegWidth-1:0]   scaled;
   logic signed [tipid_pkg::AngleWidth-1:0] angle_in;
   logic signed [tipid_pkg::AngleWidth-1:0] angle_ff;

   always_comb begin
      sum    = tipid_pkg::SumWidth'(prod_p_ff) + tipid_pkg::SumWidth'(prod_i_ff)
             + tipid_pkg::SumWidth'(prod_d_ff);
      neg    = -tipid_pkg::NegWidth'(sum);
      scaled = neg >>> tipid_pkg::ScaleShift;
      // the sum stays below 2^37, so the scaled value always fits 32 bits
      angle_in = scaled[tipid_pkg::AngleWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv3 && v2_ff) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_drive_angle = angle_ff;

endmodule

// ----- sv/tipid_csr.sv -----
// ----------------------------------------------------------------------------
// tipid_csr: configuration registers of the incremental PID tuner core
// APB-style port holding the three gains and the packed target table.
// ----------------------------------------------------------------------------
module tipid_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tipid_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [tipid_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [tipid_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output tipid_pkg::csr_cfg_type                cfg
);

   logic signed [tipid_pkg::GainWidth-1:0]  gain_p_ff;
   logic signed [tipid_pkg::GainWidth-1:0]  gain_i_ff;
   logic signed [tipid_pkg::GainWidth-1:0]  gain_d_ff;
   logic        [tipid_pkg::TableWidth-1:0] targets_ff;
   logic                                    wr_en;
   logic [tipid_pkg::RegIdxWidth-1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[tipid_pkg::CsrAddrWidth-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff  <= '0;
         gain_i_ff  <= '0;
         gain_d_ff  <= '0;
         targets_ff <= tipid_pkg::TABLE_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            tipid_pkg::REG_GAIN_P:  gain_p_ff  <= csr_pwdata[tipid_pkg::GainWidth-1:0];
            tipid_pkg::REG_GAIN_I:  gain_i_ff  <= csr_pwdata[tipid_pkg::GainWidth-1:0];
            tipid_pkg::REG_GAIN_D:  gain_d_ff  <= csr_pwdata[tipid_pkg::GainWidth-1:0];
            tipid_pkg::REG_TARGETS: targets_ff <= csr_pwdata[tipid_pkg::TableWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         tipid_pkg::REG_GAIN_P:  csr_prdata = tipid_pkg::CsrDataWidth'(unsigned'(gain_p_ff));
         tipid_pkg::REG_GAIN_I:  csr_prdata = tipid_pkg::CsrDataWidth'(unsigned'(gain_i_ff));
         tipid_pkg::REG_GAIN_D:  csr_prdata = tipid_pkg::CsrDataWidth'(unsigned'(gain_d_ff));
         tipid_pkg::REG_TARGETS: csr_prdata = tipid_pkg::CsrDataWidth'(targets_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // every register write restarts the controller history
   assign cfg.gain_p        = gain_p_ff;
   assign cfg.gain_i        = gain_i_ff;
   assign cfg.gain_d        = gain_d_ff;
   assign cfg.targets       = targets_ff;
   assign cfg.clear_history = wr_en;

endmodule

// ----- tb/tuner_incremental_pid_core_tb.sv -----
// ----------------------------------------------------------------------------
// tuner_incremental_pid_core_tb: self-checking bench for the PID tuner core
// Drives string code / frequency transfers under several idle and stall mixes,
// rewrites gains and target table between phases, and checks every drive
// angle against a cycle-free model of the error history and gain sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tuner_incremental_pid_core_tb;

   localparam int QuietLimit = 2000;
   localparam int HoldOffCycles = 100;
   localparam int RandomItemsPerPhase = 150;

   // tracks gains, targets and error history; holds the drive angles still owed
   class angle_scoreboard;
      logic signed [tipid_pkg::GainWidth-1:0] gain_p;
      logic signed [tipid_pkg::GainWidth-1:0] gain_i;
      logic signed [tipid_pkg::GainWidth-1:0] gain_d;
      logic [tipid_pkg::TableWidth-1:0]       targets;
      logic signed [tipid_pkg::ErrWidth-1:0]  last_error;
      logic signed [tipid_pkg::DiffWidth-1:0] last_error_diff;
      logic signed [tipid_pkg::AngleWidth-1:0] pending_angles[$];
      int errors;

      function new();
         gain_p = '0;
         gain_i = '0;
         gain_d = '0;
         targets = tipid_pkg::TABLE_RESET;
         last_error = '0;
         last_error_diff = '0;
         errors = 0;
      endfunction

      // target in Q.6 for a string code, -1 for none or invalid
      function int target_q6(input logic [tipid_pkg::CodeWidth-1:0] code);
         if (code == tipid_pkg::CODE_NONE || code == tipid_pkg::CODE_INVALID)
            return -1;
         return int'(targets[tipid_pkg::TargetWidth*(int'(code)-1)
                             +: tipid_pkg::TargetWidth]) * 64;
      endfunction

      function void write_setting(input logic [tipid_pkg::RegIdxWidth-1:0] idx,
                                  input logic [tipid_pkg::CsrDataWidth-1:0] value);
         case (idx)
            tipid_pkg::REG_GAIN_P:  gain_p = value[tipid_pkg::GainWidth-1:0];
            tipid_pkg::REG_GAIN_I:  gain_i = value[tipid_pkg::GainWidth-1:0];
            tipid_pkg::REG_GAIN_D:  gain_d = value[tipid_pkg::GainWidth-1:0];
            tipid_pkg::REG_TARGETS: targets = value[tipid_pkg::TableWidth-1:0];
            default: ;
         endcase
         last_error = '0;
         last_error_diff = '0;
      endfunction

      function void note_request(input logic [tipid_pkg::CodeWidth-1:0] code,
                                 input logic [tipid_pkg::FreqWidth-1:0] freq);
         longint err;
         longint d_err;
         longint dd_err;
         longint total;
         longint scaled;
         int target;
         target = target_q6(code);
         err = (target < 0) ? 0 : longint'(target) - longint'(freq);
         d_err = err - longint'(last_error);
         dd_err = d_err - longint'(last_error_diff);
         last_error = err[tipid_pkg::ErrWidth-1:0];
         last_error_diff = d_err[tipid_pkg::DiffWidth-1:0];
         total = longint'(gain_p) * d_err + longint'(gain_i) * err
               + longint'(gain_d) * dd_err;
         // arithmetic shift gives floor rounding
         scaled = (-total) >>> tipid_pkg::ScaleShift;
         if (scaled > 64'sd2147483647)
            scaled = 64'sd2147483647;
         if (scaled < -64'sd2147483648)
            scaled = -64'sd2147483648;
         pending_angles.push_back(scaled[tipid_pkg::AngleWidth-1:0]);
      endfunction

      function void check_angle(input logic signed [tipid_pkg::AngleWidth-1:0] actual);
         logic signed [tipid_pkg::AngleWidth-1:0] want;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected drive_angle %0d", $time, actual);
            errors++;
            return;
         end
         want = pending_angles.pop_front();
         if (actual !== want) begin
            $display("%0t: drive_angle mismatch: expected %0d, actual %0d",
                     $time, want, actual);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [tipid_pkg::CodeWidth-1:0] req_string_code = '0;
   logic [tipid_pkg::FreqWidth-1:0] req_measured_frequency = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [tipid_pkg::AngleWidth-1:0] rsp_drive_angle;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [tipid_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [tipid_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [tipid_pkg::CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   angle_scoreboard tracker = new();
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   int quiet_cycles = 0;

   tuner_incremental_pid_core i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_string_code        (req_string_code),
      .req_measured_frequency (req_measured_frequency),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_drive_angle        (rsp_drive_angle),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldOffCycles;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_angle(rsp_drive_angle);
         if (req_valid && req_ready)
            tracker.note_request(req_string_code, req_measured_frequency);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge; leaves valid high after the transfer
   task automatic send_item(input logic [tipid_pkg::CodeWidth-1:0] code,
                            input logic [tipid_pkg::FreqWidth-1:0] freq);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_string_code = code;
      req_measured_frequency = freq;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (tracker.pending_angles.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input logic [tipid_pkg::RegIdxWidth-1:0] idx,
                            input logic [tipid_pkg::CsrDataWidth-1:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_setting(idx, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic write_gains(input logic [tipid_pkg::CsrDataWidth-1:0] p,
                              input logic [tipid_pkg::CsrDataWidth-1:0] i,
                              input logic [tipid_pkg::CsrDataWidth-1:0] d);
      write_csr(tipid_pkg::REG_GAIN_P, p);
      write_csr(tipid_pkg::REG_GAIN_I, i);
      write_csr(tipid_pkg::REG_GAIN_D, d);
   endtask

   // tuning runs: a string held for a while, pitch converging on its target
   task automatic run_random(input int count, input bit with_hold_off);
      int sent;
      int burst;
      int delta;
      int target;
      int f;
      bit noise;
      logic [tipid_pkg::CodeWidth-1:0] code;
      sent = 0;
      while (sent < count) begin
         code = tipid_pkg::CodeWidth'($urandom_range(7));
         burst = $urandom_range(1, 12);
         delta = int'($urandom_range(8000)) - 4000;
         noise = ($urandom_range(3) == 0);
         for (int k = 0; k < burst; k++) begin
            target = tracker.target_q6(code);
            if (noise || target < 0)
               f = $urandom_range(65535);
            else
               f = target + delta;
            if (f < 0)
               f = 0;
            if (f > 65535)
               f = 65535;
            send_item(code, f[tipid_pkg::FreqWidth-1:0]);
            delta = delta / 2 + int'($urandom_range(20)) - 10;
            sent++;
            if (with_hold_off && sent == count / 3)
               hold_request = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset gains are zero: outputs stay zero whatever the error
      send_item(tipid_pkg::CODE_HIGH_E, '0);
      send_item(tipid_pkg::CODE_LOW_E, '1);
      send_item(tipid_pkg::CODE_INVALID, 16'h1234);
      drain_results();

      // unity gains over the reset target table
      write_gains(64'd256, 64'd256, 64'd256);
      for (int c = 0; c < 8; c++)
         send_item(c[tipid_pkg::CodeWidth-1:0], '0);
      for (int c = 0; c < 8; c++)
         send_item(c[tipid_pkg::CodeWidth-1:0], '1);
      send_item(tipid_pkg::CODE_A,
                tipid_pkg::FreqWidth'(tracker.target_q6(tipid_pkg::CODE_A)));
      send_item(tipid_pkg::CODE_A,
                tipid_pkg::FreqWidth'(tracker.target_q6(tipid_pkg::CODE_A)));
      send_item(tipid_pkg::CODE_G, 16'hAAAA);
      send_item(tipid_pkg::CODE_D, 16'h5555);
      send_item(tipid_pkg::CODE_B,
                tipid_pkg::FreqWidth'(tracker.target_q6(tipid_pkg::CODE_B) - 1));
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_gains(64'h0000_0000_0000_7FFF, 64'hFFFF_FFFF_FFFF_8000,
                           64'h0000_0000_0000_7FFF);
               write_csr(tipid_pkg::REG_TARGETS, 64'hFFFF_FFFF_FFFF_FFFF);
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               write_gains(64'h0000_0000_0000_8000, 64'h0000_0000_0000_7FFF,
                           64'h1234_5678_0000_8000);
               write_csr(tipid_pkg::REG_TARGETS, 64'h0);
               idle_pct = 48;
               stall_pct = 0;
            end
            2: begin
               write_gains({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
               write_csr(tipid_pkg::REG_TARGETS, {$urandom, $urandom});
               idle_pct = 0;
               stall_pct = 48;
            end
            default: begin
               write_csr(tipid_pkg::REG_TARGETS, {$urandom, $urandom});
               write_gains({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
               idle_pct = 31;
               stall_pct = 31;
            end
         endcase
         run_random(RandomItemsPerPhase, phase == 0);
         drain_results();
      end

      repeat (10) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending_angles.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
